@@ hdl/sgpf_pkg.sv @@
// Shared types and constants for the sequence gap and part finder.
package sgpf_pkg;

    localparam int MAX_RANGES_DEF = 8;
    localparam int MAX_PARTS      = 8;
    localparam int MAX_RESULTS    = 64;

    localparam int SN_W    = 63;
    localparam int WSN_W   = 64;
    localparam int PART_W  = 3;
    localparam int PARTS_W = 4;
    localparam int NRES_W  = 6;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 200;

    typedef enum logic [1:0] {
        KIND_GAP     = 2'd0,
        KIND_PART    = 2'd1,
        KIND_SUMMARY = 2'd2
    } kind_t;

    typedef struct packed {
        logic [SN_W-1:0]    start;
        logic [SN_W-1:0]    last_sn;
        logic [PART_W-1:0]  part;
        logic [PARTS_W-1:0] parts;
    } entry_t;

    typedef struct packed {
        logic load;
        logic pop;
    } cell_ctrl_t;

endpackage

@@ hdl/sgpf_cell.sv @@
// One cell of the sorting chain: holds one range, inserts in order and shifts out.
module sgpf_cell
    import sgpf_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     new_entry,
    input  entry_t     prev_entry,
    input  entry_t     next_entry,
    input  logic       prev_gt,
    input  logic       occupied,
    input  logic       at_count,
    output logic       gt,
    output entry_t     entry
);

    entry_t entry_reg;

    assign entry = entry_reg;

    // Held range sorts after the incoming one
    assign gt = occupied && ((entry_reg.start > new_entry.start) ||
                ((entry_reg.start == new_entry.start) && (entry_reg.part > new_entry.part)));

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            if (prev_gt)
            begin
                entry_reg <= prev_entry;
            end
            else if (gt || at_count)
            begin
                entry_reg <= new_entry;
            end
        end
        else if (ctrl.pop)
        begin
            entry_reg <= next_entry;
        end
    end

endmodule

@@ hdl/sequence_gap_and_part_finder.sv @@
// Sequence gap and missing-part finder: a sorting chain of cells with a group walker.
//
// Ranges stream in on s_axis, one transaction per cycle, and drop into a chain of
// MAX_RANGES cells that keeps them sorted by start and part index. The transaction
// with tlast set starts the walk: the walker reads the head of the chain and shifts
// the chain left one entry per cycle, unless an output stall holds the walk. Every
// group but the last is judged and popped, and the set closes with a summary. The
// input is held off until the final summary transaction has been loaded into the
// output register. Ranges beyond MAX_RANGES are dropped and reported in the summary.
// The user must write the committed sequence number through cfg_we/cfg_wdata only
// while the block is idle; the block itself does not enforce this.
module sequence_gap_and_part_finder
    import sgpf_pkg::*;
#(
    parameter int MAX_RANGES = MAX_RANGES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [WSN_W-1:0]      cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // range_start[62:0], range_end[125:63], range_part[128:126], range_parts[132:129]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // miss_start[62:0], miss_end[126:63], miss_part[129:127], miss_parts[133:130],
    // next_sn[196:134], overflowed[197]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // item_kind[1:0]
    output logic [1:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int CW = $clog2(MAX_RANGES + 1);

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_GROUP = 6'b000010,
        ST_PARTS = 6'b000100,
        ST_TRAIL = 6'b001000,
        ST_POP   = 6'b010000,
        ST_FINAL = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [WSN_W-1:0]   committed_reg;
    logic [WSN_W-1:0]   next_reg, next_next;
    logic [CW-1:0]      gleft_reg, gleft_next;
    logic [SN_W-1:0]    gstart_reg, gstart_next;
    logic [SN_W-1:0]    gend_reg, gend_next;
    logic [PARTS_W-1:0] gparts_reg, gparts_next;
    logic [PARTS_W-1:0] nexp_reg, nexp_next;
    logic [NRES_W-1:0]  nres_reg, nres_next;

    logic               out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [1:0]         out_kind_reg, out_kind_next;
    logic               out_last_reg, out_last_next;

    entry_t             new_entry;
    entry_t             cells [MAX_RANGES];
    logic [MAX_RANGES-1:0] gt_vec;
    logic [MAX_RANGES-1:0] same_vec;
    cell_ctrl_t         ctrl;
    logic [CW-1:0]      gcnt;
    logic               in_acc;
    logic               slot_free;
    logic               room;
    logic [PARTS_W-1:0] lim;
    entry_t             head;

    assign new_entry.start   = s_axis_tdata[62:0];
    assign new_entry.last_sn = s_axis_tdata[125:63];
    assign new_entry.part    = s_axis_tdata[128:126];
    assign new_entry.parts   = s_axis_tdata[132:129];

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign room          = (7'(nres_reg) < 7'(MAX_RESULTS - 1));
    assign head          = cells[0];
    assign lim = (7'(gparts_reg) > 7'(MAX_PARTS)) ? 4'(MAX_PARTS) : gparts_reg;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_RANGES; gi++)
        begin : g_cell
            entry_t prev_e, next_e;
            logic   prev_g;
            if (gi == 0)
            begin : g_first
                assign prev_e = new_entry;
                assign prev_g = 1'b0;
            end
            else
            begin : g_mid
                assign prev_e = cells[gi-1];
                assign prev_g = gt_vec[gi-1];
            end
            if (gi == MAX_RANGES - 1)
            begin : g_end
                assign next_e = cells[gi];
            end
            else
            begin : g_nxt
                assign next_e = cells[gi+1];
            end

            sgpf_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .new_entry  (new_entry),
                .prev_entry (prev_e),
                .next_entry (next_e),
                .prev_gt    (prev_g),
                .occupied   (CW'(gi) < count_reg),
                .at_count   (CW'(gi) == count_reg),
                .gt         (gt_vec[gi]),
                .entry      (cells[gi])
            );

            assign same_vec[gi] = (CW'(gi) < count_reg) && (cells[gi].start == head.start);
        end
    endgenerate

    // Size of the head group
    always_comb
    begin
        gcnt = '0;
        for (int i = 0; i < MAX_RANGES; i++)
        begin
            gcnt = gcnt + CW'(same_vec[i]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        next_next      = next_reg;
        gleft_next     = gleft_reg;
        gstart_next    = gstart_reg;
        gend_next      = gend_reg;
        gparts_next    = gparts_reg;
        nexp_next      = nexp_reg;
        nres_next      = nres_reg;
        ctrl.load      = 1'b0;
        ctrl.pop       = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (count_reg == CW'(MAX_RANGES))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.load  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        next_next  = committed_reg + 1'b1;
                        state_next = ST_GROUP;
                    end
                end
            end

            ST_GROUP:
            begin
                if (count_reg == '0 || gcnt == count_reg)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    gstart_next = head.start;
                    gend_next   = head.last_sn;
                    gparts_next = head.parts;
                    gleft_next  = gcnt;
                    nexp_next   = '0;
                    if (7'(head.parts) == 7'(gcnt))
                    begin
                        if ({1'b0, head.start} == next_reg)
                        begin
                            next_next  = {1'b0, head.last_sn} + 1'b1;
                            state_next = ST_POP;
                        end
                        else if (!room)
                        begin
                            state_next = ST_POP;
                        end
                        else if (slot_free)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_GAP;
                            out_last_next  = 1'b0;
                            out_data_next  = '0;
                            out_data_next[62:0]   = next_reg[SN_W-1:0];
                            out_data_next[126:63] = {1'b0, head.start} - 1'b1;
                            nres_next  = nres_reg + 1'b1;
                            state_next = ST_POP;
                        end
                    end
                    else
                    begin
                        state_next = ST_PARTS;
                    end
                end
            end

            ST_POP:
            begin
                ctrl.pop   = 1'b1;
                count_next = count_reg - 1'b1;
                gleft_next = gleft_reg - 1'b1;
                if (gleft_reg == CW'(1))
                begin
                    state_next = ST_GROUP;
                end
            end

            ST_PARTS:
            begin
                if (nexp_reg < {1'b0, head.part})
                begin
                    if (!room)
                    begin
                        nexp_next = nexp_reg + 1'b1;
                    end
                    else if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_PART;
                        out_last_next  = 1'b0;
                        out_data_next  = '0;
                        out_data_next[62:0]    = gstart_reg;
                        out_data_next[126:63]  = {1'b0, gend_reg};
                        out_data_next[129:127] = nexp_reg[PART_W-1:0];
                        out_data_next[133:130] = gparts_reg;
                        nres_next = nres_reg + 1'b1;
                        nexp_next = nexp_reg + 1'b1;
                    end
                end
                else
                begin
                    nexp_next  = {1'b0, head.part} + 1'b1;
                    ctrl.pop   = 1'b1;
                    count_next = count_reg - 1'b1;
                    gleft_next = gleft_reg - 1'b1;
                    if (gleft_reg == CW'(1))
                    begin
                        state_next = ST_TRAIL;
                    end
                end
            end

            ST_TRAIL:
            begin
                if (nexp_reg < lim)
                begin
                    if (!room)
                    begin
                        nexp_next = nexp_reg + 1'b1;
                    end
                    else if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = KIND_PART;
                        out_last_next  = 1'b0;
                        out_data_next  = '0;
                        out_data_next[62:0]    = gstart_reg;
                        out_data_next[126:63]  = {1'b0, gend_reg};
                        out_data_next[129:127] = nexp_reg[PART_W-1:0];
                        out_data_next[133:130] = gparts_reg;
                        nres_next = nres_reg + 1'b1;
                        nexp_next = nexp_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_GROUP;
                end
            end

            ST_FINAL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_SUMMARY;
                    out_last_next  = 1'b1;
                    out_data_next  = '0;
                    out_data_next[196:134] = next_reg[SN_W-1:0];
                    out_data_next[197]     = ovf_reg;
                    count_next = '0;
                    ovf_next   = 1'b0;
                    nres_next  = '0;
                    state_next = ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            nres_reg      <= '0;
            out_valid_reg <= 1'b0;
            committed_reg <= '1;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            nres_reg      <= nres_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                committed_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        next_reg     <= next_next;
        gleft_reg    <= gleft_next;
        gstart_reg   <= gstart_next;
        gend_reg     <= gend_next;
        gparts_reg   <= gparts_next;
        nexp_reg     <= nexp_next;
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the sequence gap and part finder, with a built-in predictor.
`timescale 1ns / 100ps

module testbench;
    import sgpf_pkg::*;

    typedef struct {
        logic [SN_W-1:0]    start;
        logic [SN_W-1:0]    stop;
        logic [PART_W-1:0]  part;
        logic [PARTS_W-1:0] parts;
        logic               last;
    } range_t;

    typedef struct {
        kind_t              kind;
        logic [SN_W-1:0]    ms;
        logic [WSN_W-1:0]   me;
        logic [PART_W-1:0]  mp;
        logic [PARTS_W-1:0] mps;
        logic [SN_W-1:0]    nx;
        logic               ov;
        logic               last;
    } finding_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [WSN_W-1:0]      cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    sequence_gap_and_part_finder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // predictor state
    logic [SN_W-1:0]    st_start [MAX_RANGES_DEF];
    logic [SN_W-1:0]    st_end   [MAX_RANGES_DEF];
    logic [PART_W-1:0]  st_part  [MAX_RANGES_DEF];
    logic [PARTS_W-1:0] st_parts [MAX_RANGES_DEF];
    int                 held_count;
    logic               dropped_flag;
    logic [WSN_W-1:0]   committed_val;
    int                 run_findings;

    range_t   range_q[$];
    finding_t finding_q[$];

    int  mismatches;
    int  sets_sent;
    int  ranges_sent;
    int  kind_seen [3];
    bit  s_taken;
    int  s_gap;
    int  m_stall;
    bit  no_idle;

    always #1 clk = ~clk;

    function automatic void add_finding(kind_t k, logic [SN_W-1:0] ms, logic [WSN_W-1:0] me,
                                        logic [PART_W-1:0] mp, logic [PARTS_W-1:0] mps,
                                        logic [SN_W-1:0] nx, logic ov, logic last);
        finding_t f;
        f.kind = k; f.ms = ms; f.me = me; f.mp = mp; f.mps = mps;
        f.nx = nx; f.ov = ov; f.last = last;
        finding_q = {finding_q, f};
    endfunction

    function automatic void add_missing(int g, int j);
        if (run_findings < MAX_RESULTS - 1)
        begin
            add_finding(KIND_PART, st_start[g], {1'b0, st_end[g]}, j[PART_W-1:0],
                        st_parts[g], '0, 1'b0, 1'b0);
            run_findings++;
        end
    endfunction

    function automatic void judge_group(int g, int stop, int cnt, ref logic [WSN_W-1:0] nx);
        int nexp;
        int lim;
        nexp = 0;
        if (int'(st_parts[g]) == cnt)
        begin
            if ({1'b0, st_start[g]} == nx)
                nx = {1'b0, st_end[g]} + 64'd1;
            else if (run_findings < MAX_RESULTS - 1)
            begin
                add_finding(KIND_GAP, nx[SN_W-1:0], {1'b0, st_start[g]} - 64'd1,
                            '0, '0, '0, 1'b0, 1'b0);
                run_findings++;
            end
            return;
        end
        for (int k = g; k < stop; k++)
        begin
            for (int j = nexp; j < int'(st_part[k]); j++)
                add_missing(g, j);
            nexp = int'(st_part[k]) + 1;
        end
        lim = (st_parts[g] > MAX_PARTS) ? MAX_PARTS : int'(st_parts[g]);
        for (; nexp < lim; nexp++)
            add_missing(g, nexp);
    endfunction

    // Insert one range into the sorted store and, on the last one, walk the groups.
    function automatic void absorb_range(range_t r);
        int pos;
        int g;
        int cnt;
        logic [WSN_W-1:0] nx;
        if (held_count < MAX_RANGES_DEF)
        begin
            pos = held_count;
            while (pos > 0 && (st_start[pos-1] > r.start ||
                   (st_start[pos-1] == r.start && st_part[pos-1] > r.part)))
            begin
                st_start[pos] = st_start[pos-1];
                st_end[pos]   = st_end[pos-1];
                st_part[pos]  = st_part[pos-1];
                st_parts[pos] = st_parts[pos-1];
                pos--;
            end
            st_start[pos] = r.start;
            st_end[pos]   = r.stop;
            st_part[pos]  = r.part;
            st_parts[pos] = r.parts;
            held_count++;
        end
        else
            dropped_flag = 1'b1;
        if (!r.last)
            return;
        nx = committed_val + 64'd1;
        g = 0;
        cnt = 1;
        run_findings = 0;
        for (int i = 1; i < held_count; i++)
        begin
            if (st_start[i] == st_start[g])
                cnt++;
            else
            begin
                judge_group(g, i, cnt, nx);
                g = i;
                cnt = 1;
            end
        end
        add_finding(KIND_SUMMARY, '0, '0, '0, '0, nx[SN_W-1:0], dropped_flag, 1'b1);
        held_count = 0;
        dropped_flag = 1'b0;
    endfunction

    function automatic void queue_range(logic [SN_W-1:0] s, logic [SN_W-1:0] e,
                                        logic [PART_W-1:0] p, logic [PARTS_W-1:0] ps,
                                        logic last);
        range_t r;
        r.start = s; r.stop = e; r.part = p; r.parts = ps; r.last = last;
        range_q = {range_q, r};
        ranges_sent++;
        if (last)
            sets_sent++;
    endfunction

    function automatic logic [SN_W-1:0] rand_sn();
        return 63'({$urandom, $urandom});
    endfunction

    function automatic int rand_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Well-formed set: groups laid out from next expected, with some holes and defects.
    task automatic queue_good_set();
        range_t pool[$];
        range_t r;
        logic [SN_W-1:0] sn;
        int ngroups;
        int np;
        int idx;
        sn = committed_val[SN_W-1:0] + 63'd1;
        ngroups = $urandom_range(2, 4);
        for (int gi = 0; gi < ngroups && pool.size() < MAX_RANGES_DEF; gi++)
        begin
            if ($urandom_range(0, 4) == 0)
                sn = sn + $urandom_range(1, 5);
            else if ($urandom_range(0, 19) == 0)
                sn = sn - $urandom_range(1, 3);
            np = $urandom_range(1, 4);
            r.start = sn;
            r.stop  = sn + $urandom_range(0, 20);
            r.last  = 1'b0;
            r.parts = 4'(np);
            if ($urandom_range(0, 9) == 0)
                r.parts = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
            idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, np - 1) : -1;
            for (int p = 0; p < np && pool.size() < MAX_RANGES_DEF; p++)
            begin
                if (p == idx)
                    continue;
                r.part = 3'(p);
                pool = {pool, r};
                if ($urandom_range(0, 9) == 0 && pool.size() < MAX_RANGES_DEF)
                    pool = {pool, r};
            end
            sn = r.stop + 63'd1;
        end
        while (pool.size() > 0)
        begin
            idx = $urandom_range(0, pool.size() - 1);
            r = pool[idx];
            pool.delete(idx);
            queue_range(r.start, r.stop, r.part, r.parts, pool.size() == 0);
        end
    endtask

    // Noise set: full-width fields, small start space so groups still form, maybe overflow.
    task automatic queue_noise_set();
        int n;
        logic [SN_W-1:0] s;
        n = $urandom_range(1, 11);
        for (int i = 0; i < n; i++)
        begin
            s = ($urandom_range(0, 1) == 0) ? rand_sn() : 63'($urandom_range(0, 3));
            queue_range(s, rand_sn(), 3'($urandom), 4'($urandom), i == n - 1);
        end
    endtask

    task automatic write_committed(logic [WSN_W-1:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        committed_val = v;
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (range_q.size() != 0 || s_axis_tvalid || finding_q.size() != 0);
        repeat (150) @(posedge clk);
    endtask

    initial
    begin
        logic [WSN_W-1:0] cfg_pick;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        held_count = 0;
        dropped_flag = 1'b0;
        committed_val = '1;
        mismatches = 0;
        sets_sent = 0;
        ranges_sent = 0;
        kind_seen = '{0, 0, 0};
        s_taken = 1'b0;
        s_gap = 0;
        m_stall = 0;
        no_idle = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, zero and oversize part counts, duplicate, overflow
        write_committed('1);
        queue_range(63'd0, 63'd4, 3'd0, 4'd1, 1'b0);
        queue_range(63'd5, 63'd9, 3'd1, 4'd3, 1'b0);
        queue_range(63'd5, 63'd9, 3'd1, 4'd3, 1'b0);
        queue_range(63'd7, '1, 3'd7, 4'd15, 1'b0);
        queue_range(63'd8, 63'd8, 3'd0, 4'd0, 1'b0);
        queue_range('1, '1, 3'd7, 4'd8, 1'b1);
        for (int i = 0; i < 10; i++)
            queue_range(63'd20 - i, 63'd30, i[2:0], 4'd1, i == 9);
        drain();
        write_committed(64'd9223372036854775806);
        queue_range('1, '1, 3'd0, 4'd1, 1'b0);
        queue_range(63'd3, 63'd3, 3'd0, 4'd1, 1'b0);
        queue_range('1, '0, 3'd0, 4'd1, 1'b1);
        queue_range(63'd0, 63'd0, 3'd5, 4'd8, 1'b1);
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph % 5)
                0: cfg_pick = '1;
                1: cfg_pick = '0;
                2: cfg_pick = 64'd9223372036854775806;
                3: cfg_pick = 64'($urandom_range(0, 1000));
                default: cfg_pick = {1'b0, rand_sn() >> 1};
            endcase
            write_committed(cfg_pick);
            no_idle = (ph == 4);
            for (int k = 0; k < 6; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                    queue_noise_set();
                else
                    queue_good_set();
            end
            drain();
        end

        $display("Checked %0d sets, %0d ranges: %0d gap, %0d part, %0d summary results.",
                 sets_sent, ranges_sent, kind_seen[0], kind_seen[1], kind_seen[2]);
        $display("Committed number swept through -1, 0, the maximum and random values.");
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // range sender: hold until accepted, then advance after a random gap
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || s_taken))
        begin
            if (s_gap > 0 || range_q.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
                if (s_gap > 0)
                    s_gap <= s_gap - 1;
            end
            else
            begin
                range_t r;
                r = range_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {3'b0, r.parts, r.part, r.stop, r.start};
                s_axis_tlast <= r.last;
                s_gap <= rand_gap();
            end
        end
        if (rst_n)
        begin
            if (m_stall > 0)
            begin
                m_axis_tready <= 1'b0;
                m_stall <= m_stall - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                m_stall <= rand_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        s_taken <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
        begin
            range_t r;
            r.start = s_axis_tdata[62:0];
            r.stop  = s_axis_tdata[125:63];
            r.part  = s_axis_tdata[128:126];
            r.parts = s_axis_tdata[132:129];
            r.last  = s_axis_tlast;
            absorb_range(r);
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            finding_t got;
            finding_t want;
            got.kind = kind_t'(m_axis_tuser);
            got.ms   = m_axis_tdata[62:0];
            got.me   = m_axis_tdata[126:63];
            got.mp   = m_axis_tdata[129:127];
            got.mps  = m_axis_tdata[133:130];
            got.nx   = m_axis_tdata[196:134];
            got.ov   = m_axis_tdata[197];
            got.last = m_axis_tlast;
            if (m_axis_tuser < 3)
                kind_seen[m_axis_tuser]++;
            if (finding_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d start %0h", got.kind, got.ms);
            end
            else
            begin
                want = finding_q.pop_front();
                if (got.kind !== want.kind || got.ms !== want.ms || got.me !== want.me ||
                    got.mp !== want.mp || got.mps !== want.mps || got.nx !== want.nx ||
                    got.ov !== want.ov || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch exp: kind %0d ms %0h me %0h mp %0d mps %0d",
                                 want.kind, want.ms, want.me, want.mp, want.mps);
                        $display("              nx %0h ov %0b last %0b",
                                 want.nx, want.ov, want.last);
                        $display("         got: kind %0d ms %0h me %0h mp %0d mps %0d",
                                 got.kind, got.ms, got.me, got.mp, got.mps);
                        $display("              nx %0h ov %0b last %0b",
                                 got.nx, got.ov, got.last);
                    end
                end
            end
        end
    end

endmodule
